FILE: rtl/plct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plct_pkg
// Shared constants, codes and state types of the curve table unit.
// ----------------------------------------------------------------------------
package plct_pkg;

    localparam int MAX_POINTS = 20;
    localparam int DATA_W     = 32;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int MAG_W      = DATA_W + 1;
    localparam int MLO_W      = (MAG_W + 1) / 2;
    localparam int MHI_W      = MAG_W - MLO_W;
    localparam int PROD_W     = 2 * MAG_W;
    localparam int SUM_W      = DATA_W + 3;
    localparam int DCNT_W     = $clog2(MAG_W);

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

    typedef enum logic [2:0] {
        OP_EVAL = 3'd0,
        OP_INV  = 3'd1,
        OP_INS  = 3'd2,
        OP_DEL  = 3'd3,
        OP_WR   = 3'd4
    } t_opcode;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_EV_FIRST,
        S_EV_LAST,
        S_EV_SCAN,
        S_INV_WIN,
        S_INV_CHK,
        S_INV_MM0,
        S_INV_MM,
        S_INV_DEC,
        S_INV_PICK,
        S_INV_SEG,
        S_LD0,
        S_LD1,
        S_ISTART,
        S_IWAIT,
        S_INS_A,
        S_INS_B,
        S_INS_W,
        S_DEL_W,
        S_WR_W,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        I_IDLE,
        I_MUL0,
        I_MUL1,
        I_CHK,
        I_DIV,
        I_FIN
    } t_istate;

    function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] vmax;
        logic signed [SUM_W-1:0] vmin;
        vmax = SUM_W'({1'b0, {(DATA_W-1){1'b1}}});
        vmin = -vmax - SUM_W'(1);
        if (v > vmax) begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end else if (v < vmin) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end
        return v[DATA_W-1:0];
    endfunction

endpackage

FILE: rtl/plct_interp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plct_interp
// Linear interpolation b0 + (b1-b0)*(t-a0)/(a1-a0), offset truncated toward
// zero and clamped, using a split multiplier and a bit-serial divider.
// ----------------------------------------------------------------------------
module plct_interp
    import plct_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [DATA_W-1:0] i_a0,
    input  logic signed [DATA_W-1:0] i_b0,
    input  logic signed [DATA_W-1:0] i_a1,
    input  logic signed [DATA_W-1:0] i_b1,
    input  logic signed [DATA_W-1:0] i_t,
    output logic                     o_done,
    output logic signed [DATA_W-1:0] o_value
);

    localparam logic [MAG_W-1:0] Q_CLAMP = {1'b1, {(MAG_W-1){1'b0}}};

    t_istate r_state, n_state;
    logic                     r_done, n_done;
    logic signed [DATA_W-1:0] r_value, n_value;
    logic                     r_neg, n_neg;
    logic [MAG_W-1:0]         r_ms, n_ms;
    logic [MAG_W-1:0]         r_ma, n_ma;
    logic [MAG_W-1:0]         r_mb, n_mb;
    logic [PROD_W-1:0]        r_prod, n_prod;
    logic [MAG_W-1:0]         r_rem, n_rem;
    logic [MAG_W-1:0]         r_sh, n_sh;
    logic [MAG_W-1:0]         r_q, n_q;
    logic [DCNT_W-1:0]        r_cnt, n_cnt;

    logic signed [MAG_W-1:0]  span, da, db;
    logic [MLO_W-1:0]         mul_b;
    logic [MAG_W+MLO_W-1:0]   mul_p;
    logic [MAG_W:0]           trial;
    logic                     ge;
    logic [MAG_W-1:0]         qc;
    logic signed [SUM_W-1:0]  sum;

    assign span  = {i_a1[DATA_W-1], i_a1} - {i_a0[DATA_W-1], i_a0};
    assign da    = {i_t[DATA_W-1], i_t} - {i_a0[DATA_W-1], i_a0};
    assign db    = {i_b1[DATA_W-1], i_b1} - {i_b0[DATA_W-1], i_b0};
    assign mul_b = (r_state == I_MUL0) ? r_mb[MLO_W-1:0]
                                       : MLO_W'(r_mb[MAG_W-1:MLO_W]);
    assign mul_p = r_ma * mul_b;
    assign trial = {r_rem, r_sh[MAG_W-1]};
    assign ge    = trial >= {1'b0, r_ms};
    assign qc    = (r_q > Q_CLAMP) ? Q_CLAMP : r_q;
    assign sum   = r_neg ? (SUM_W'(i_b0) - $signed(SUM_W'(qc)))
                         : (SUM_W'(i_b0) + $signed(SUM_W'(qc)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= I_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_value <= n_value;
        r_neg   <= n_neg;
        r_ms    <= n_ms;
        r_ma    <= n_ma;
        r_mb    <= n_mb;
        r_prod  <= n_prod;
        r_rem   <= n_rem;
        r_sh    <= n_sh;
        r_q     <= n_q;
        r_cnt   <= n_cnt;
    end

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        n_value = r_value;
        n_neg   = r_neg;
        n_ms    = r_ms;
        n_ma    = r_ma;
        n_mb    = r_mb;
        n_prod  = r_prod;
        n_rem   = r_rem;
        n_sh    = r_sh;
        n_q     = r_q;
        n_cnt   = r_cnt;
        case (r_state)
            I_IDLE: begin
                if (i_start) begin
                    if (span == '0 || da == '0 || db == '0) begin
                        n_value = i_b0;
                        n_done  = 1'b1;
                    end else begin
                        n_neg   = span[MAG_W-1] ^ da[MAG_W-1] ^ db[MAG_W-1];
                        n_ms    = span[MAG_W-1] ? MAG_W'(-span) : MAG_W'(span);
                        n_ma    = da[MAG_W-1] ? MAG_W'(-da) : MAG_W'(da);
                        n_mb    = db[MAG_W-1] ? MAG_W'(-db) : MAG_W'(db);
                        n_state = I_MUL0;
                    end
                end
            end
            I_MUL0: begin
                n_prod  = PROD_W'(mul_p);
                n_state = I_MUL1;
            end
            I_MUL1: begin
                n_prod  = r_prod + PROD_W'({mul_p, {MLO_W{1'b0}}});
                n_state = I_CHK;
            end
            I_CHK: begin
                if (r_prod[PROD_W-1:MAG_W] >= r_ms) begin
                    n_q     = Q_CLAMP;
                    n_state = I_FIN;
                end else begin
                    n_rem   = r_prod[PROD_W-1:MAG_W];
                    n_sh    = r_prod[MAG_W-1:0];
                    n_q     = '0;
                    n_cnt   = DCNT_W'(MAG_W - 1);
                    n_state = I_DIV;
                end
            end
            I_DIV: begin
                n_rem = ge ? MAG_W'(trial - {1'b0, r_ms}) : trial[MAG_W-1:0];
                n_q   = {r_q[MAG_W-2:0], ge};
                n_sh  = {r_sh[MAG_W-2:0], 1'b0};
                if (r_cnt == '0) begin
                    n_state = I_FIN;
                end else begin
                    n_cnt = r_cnt - DCNT_W'(1);
                end
            end
            I_FIN: begin
                n_value = sat_data(sum);
                n_done  = 1'b1;
                n_state = I_IDLE;
            end
            default: begin
                n_state = I_IDLE;
            end
        endcase
    end

    assign o_done  = r_done;
    assign o_value = r_value;

endmodule

FILE: rtl/piecewise_linear_curve_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_curve_table_unit
// Editable table of up to 20 Q16.16 breakpoints with evaluate, inverse
// lookup, insert, delete and write operations.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall, one operation item per handshake.
// Output channel: o_valid / i_stall, one result item per operation.
// o_stall is low only while the unit is idle; after an item is taken it
// stays high until the result has been loaded into the output register.
// Evaluate and inverse lookup walk the table one breakpoint a cycle
// through a single read port, then run the interpolator: a split 33x17
// multiplier (low half, then high half) and a one-bit-a-step divider.
// The output register holds a result while i_stall is high; the next item
// can be accepted meanwhile, but its result waits for the register.
// Reset empties the table (point count zero); stored points are undefined
// until written and need no clearing.
// ----------------------------------------------------------------------------
module piecewise_linear_curve_table_unit
    import plct_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [2:0]               i_opcode,
    input  logic [4:0]               i_point_index,
    input  logic signed [DATA_W-1:0] i_x_value,
    input  logic signed [DATA_W-1:0] i_y_value,
    input  logic signed [DATA_W-1:0] i_window_low,
    input  logic signed [DATA_W-1:0] i_window_high,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [DATA_W-1:0] o_result_value,
    output logic [4:0]               o_selected_index,
    output logic                     o_status,
    output logic [4:0]               o_points_held
);

    t_state r_state, n_state;

    logic signed [DATA_W-1:0] r_xp [MAX_POINTS];
    logic signed [DATA_W-1:0] r_yp [MAX_POINTS];

    logic [2:0]               r_op;
    logic [4:0]               r_idx;
    logic signed [DATA_W-1:0] r_xv, r_yv, r_wl, r_wh;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic [IDX_W-1:0]         r_ptr, n_ptr;
    logic [IDX_W-1:0]         r_lo, n_lo, r_hi, n_hi;
    logic                     r_lo_ok, n_lo_ok, r_hi_ok, n_hi_ok;
    logic signed [DATA_W-1:0] r_ymin, n_ymin, r_ymax, n_ymax;
    logic [IDX_W-1:0]         r_imin, n_imin, r_imax, n_imax;
    logic [IDX_W-1:0]         r_pidx, n_pidx;
    logic signed [DATA_W-1:0] r_a0, n_a0, r_b0, n_b0, r_a1, n_a1, r_b1, n_b1;
    logic signed [DATA_W-1:0] r_res, n_res;
    logic                     r_ok, n_ok;
    logic [4:0]               r_sel, n_sel;
    logic                     r_end, n_end;

    logic                     r_ovalid, n_ovalid;
    logic signed [DATA_W-1:0] r_ores, n_ores;
    logic [4:0]               r_osel, n_osel;
    logic                     r_ostat, n_ostat;
    logic [4:0]               r_ocnt, n_ocnt;

    logic signed [DATA_W-1:0] rd_x, rd_y;
    logic                     accept;
    logic [IDX_W-1:0]         last;
    logic [IDX_W-1:0]         ins_k;
    logic [IDX_W-1:0]         idx_w;
    logic signed [MAG_W-1:0]  step, xsum, ysum;
    logic signed [SUM_W-1:0]  xext;
    logic signed [DATA_W-1:0] new_x, new_y;
    logic                     rising;
    logic                     i_start, i_done;
    logic signed [DATA_W-1:0] i_value, i_tgt;

    assign rd_x   = r_xp[r_ptr];
    assign rd_y   = r_yp[r_ptr];
    assign accept = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);
    assign last   = IDX_W'(r_cnt - CNT_W'(1));
    assign idx_w  = r_idx[IDX_W-1:0];
    assign ins_k  = idx_w + IDX_W'(1);
    assign rising = r_imin < r_imax;

    // new point for insert: x extrapolated and y repeated at the end, else the floor midpoint
    assign step  = {r_a0[DATA_W-1], r_a0} - {r_a1[DATA_W-1], r_a1};
    assign xext  = SUM_W'(r_a0) + SUM_W'(step);
    assign xsum  = {r_a0[DATA_W-1], r_a0} + {r_a1[DATA_W-1], r_a1};
    assign ysum  = {r_b0[DATA_W-1], r_b0} + {r_b1[DATA_W-1], r_b1};
    assign new_x = r_end ? sat_data(xext) : xsum[MAG_W-1:1];
    assign new_y = r_end ? r_b0 : ysum[MAG_W-1:1];

    assign i_start = (r_state == S_ISTART);
    assign i_tgt   = (r_op == OP_EVAL) ? r_xv : r_yv;

    plct_interp u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_a0    (r_a0),
        .i_b0    (r_b0),
        .i_a1    (r_a1),
        .i_b1    (r_b1),
        .i_t     (i_tgt),
        .o_done  (i_done),
        .o_value (i_value)
    );

    for (genvar g = 0; g < MAX_POINTS; g++) begin : g_entry
        localparam logic [IDX_W-1:0] J = IDX_W'(g);
        always_ff @(posedge i_clk) begin
            case (r_state)
                S_INS_W: begin
                    if (J == ins_k) begin
                        r_xp[g] <= new_x;
                        r_yp[g] <= new_y;
                    end else if (g > 0 && J > ins_k && CNT_W'(J) <= r_cnt) begin
                        r_xp[g] <= r_xp[(g > 0) ? g - 1 : 0];
                        r_yp[g] <= r_yp[(g > 0) ? g - 1 : 0];
                    end
                end
                S_DEL_W: begin
                    if (g < MAX_POINTS - 1 && J >= idx_w
                            && CNT_W'(J) + CNT_W'(1) < r_cnt) begin
                        r_xp[g] <= r_xp[(g < MAX_POINTS - 1) ? g + 1 : g];
                        r_yp[g] <= r_yp[(g < MAX_POINTS - 1) ? g + 1 : g];
                    end
                end
                S_WR_W: begin
                    if (J == idx_w) begin
                        r_xp[g] <= r_xv;
                        r_yp[g] <= r_yv;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
        if (accept) begin
            r_op  <= i_opcode;
            r_idx <= i_point_index;
            r_xv  <= i_x_value;
            r_yv  <= i_y_value;
            r_wl  <= i_window_low;
            r_wh  <= i_window_high;
        end
        r_ptr   <= n_ptr;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_lo_ok <= n_lo_ok;
        r_hi_ok <= n_hi_ok;
        r_ymin  <= n_ymin;
        r_ymax  <= n_ymax;
        r_imin  <= n_imin;
        r_imax  <= n_imax;
        r_pidx  <= n_pidx;
        r_a0    <= n_a0;
        r_b0    <= n_b0;
        r_a1    <= n_a1;
        r_b1    <= n_b1;
        r_res   <= n_res;
        r_ok    <= n_ok;
        r_sel   <= n_sel;
        r_end   <= n_end;
        r_ores  <= n_ores;
        r_osel  <= n_osel;
        r_ostat <= n_ostat;
        r_ocnt  <= n_ocnt;
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_ptr    = r_ptr;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_lo_ok  = r_lo_ok;
        n_hi_ok  = r_hi_ok;
        n_ymin   = r_ymin;
        n_ymax   = r_ymax;
        n_imin   = r_imin;
        n_imax   = r_imax;
        n_pidx   = r_pidx;
        n_a0     = r_a0;
        n_b0     = r_b0;
        n_a1     = r_a1;
        n_b1     = r_b1;
        n_res    = r_res;
        n_ok     = r_ok;
        n_sel    = r_sel;
        n_end    = r_end;
        n_ovalid = r_ovalid && i_stall;
        n_ores   = r_ores;
        n_osel   = r_osel;
        n_ostat  = r_ostat;
        n_ocnt   = r_ocnt;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_sel   = i_point_index;
                    n_ok    = 1'b0;
                    n_res   = '0;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_state = S_DONE;
                case (r_op)
                    OP_EVAL: begin
                        if (r_cnt != '0) begin
                            n_ptr   = '0;
                            n_state = S_EV_FIRST;
                        end
                    end
                    OP_INV: begin
                        if (r_cnt != '0) begin
                            n_ptr = '0;
                            if (r_wl == r_wh) begin
                                n_lo    = '0;
                                n_hi    = last;
                                n_state = S_INV_MM0;
                            end else begin
                                n_lo_ok = 1'b0;
                                n_hi_ok = 1'b0;
                                n_state = S_INV_WIN;
                            end
                        end
                    end
                    OP_INS: begin
                        if (r_cnt < CNT_MAX && CNT_W'(r_idx) < r_cnt) begin
                            n_ptr   = idx_w;
                            n_end   = (idx_w == last);
                            n_state = S_INS_A;
                        end
                    end
                    OP_DEL: begin
                        if (r_cnt >= CNT_W'(3) && CNT_W'(r_idx) < r_cnt) begin
                            n_state = S_DEL_W;
                        end
                    end
                    OP_WR: begin
                        if (CNT_W'(r_idx) < r_cnt
                                || (CNT_W'(r_idx) == r_cnt && r_cnt < CNT_MAX)) begin
                            n_state = S_WR_W;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_EV_FIRST: begin
                if (r_xv <= rd_x) begin
                    n_res   = rd_y;
                    n_ok    = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_a0    = rd_x;
                    n_b0    = rd_y;
                    n_ptr   = last;
                    n_state = S_EV_LAST;
                end
            end
            S_EV_LAST: begin
                if (rd_x <= r_xv) begin
                    n_res   = rd_y;
                    n_ok    = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_ptr   = IDX_W'(1);
                    n_state = S_EV_SCAN;
                end
            end
            S_EV_SCAN: begin
                if (r_xv < rd_x || r_ptr == last) begin
                    n_a1    = rd_x;
                    n_b1    = rd_y;
                    n_state = S_ISTART;
                end else begin
                    n_a0  = rd_x;
                    n_b0  = rd_y;
                    n_ptr = r_ptr + IDX_W'(1);
                end
            end
            S_INV_WIN: begin
                if (!r_lo_ok && r_wl < rd_x) begin
                    n_lo    = r_ptr;
                    n_lo_ok = 1'b1;
                end
                if (rd_x < r_wh) begin
                    n_hi    = r_ptr;
                    n_hi_ok = 1'b1;
                end
                if (r_ptr == last) begin
                    n_state = S_INV_CHK;
                end else begin
                    n_ptr = r_ptr + IDX_W'(1);
                end
            end
            S_INV_CHK: begin
                if (!r_lo_ok || !r_hi_ok || r_hi < r_lo) begin
                    n_state = S_DONE;
                end else begin
                    n_ptr   = r_lo;
                    n_state = S_INV_MM0;
                end
            end
            S_INV_MM0: begin
                n_ymin = rd_y;
                n_ymax = rd_y;
                n_imin = r_ptr;
                n_imax = r_ptr;
                if (r_ptr == r_hi) begin
                    n_state = S_INV_DEC;
                end else begin
                    n_ptr   = r_ptr + IDX_W'(1);
                    n_state = S_INV_MM;
                end
            end
            S_INV_MM: begin
                if (rd_y < r_ymin) begin
                    n_ymin = rd_y;
                    n_imin = r_ptr;
                end
                if (r_ymax < rd_y) begin
                    n_ymax = rd_y;
                    n_imax = r_ptr;
                end
                if (r_ptr == r_hi) begin
                    n_state = S_INV_DEC;
                end else begin
                    n_ptr = r_ptr + IDX_W'(1);
                end
            end
            S_INV_DEC: begin
                if (r_ymax <= r_yv) begin
                    n_ptr   = r_imax;
                    n_state = S_INV_PICK;
                end else if (r_yv <= r_ymin) begin
                    n_ptr   = r_imin;
                    n_state = S_INV_PICK;
                end else begin
                    n_ptr   = r_lo + IDX_W'(1);
                    n_state = S_INV_SEG;
                end
            end
            S_INV_PICK: begin
                n_res   = rd_x;
                n_ok    = 1'b1;
                n_state = S_DONE;
            end
            S_INV_SEG: begin
                if (r_ptr == r_hi || (rising ? (r_yv < rd_y) : (rd_y < r_yv))) begin
                    if (rising) begin
                        n_ptr  = r_ptr - IDX_W'(1);
                        n_pidx = r_ptr;
                    end else begin
                        n_pidx = r_ptr - IDX_W'(1);
                    end
                    n_state = S_LD0;
                end else begin
                    n_ptr = r_ptr + IDX_W'(1);
                end
            end
            S_LD0: begin
                n_a0    = rd_y;
                n_b0    = rd_x;
                n_ptr   = r_pidx;
                n_state = S_LD1;
            end
            S_LD1: begin
                n_a1    = rd_y;
                n_b1    = rd_x;
                n_state = S_ISTART;
            end
            S_ISTART: begin
                n_state = S_IWAIT;
            end
            S_IWAIT: begin
                if (i_done) begin
                    n_res   = i_value;
                    n_ok    = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_INS_A: begin
                n_a0 = rd_x;
                n_b0 = rd_y;
                if (!r_end) begin
                    n_ptr = ins_k;
                end else if (idx_w != '0) begin
                    n_ptr = idx_w - IDX_W'(1);
                end
                n_state = S_INS_B;
            end
            S_INS_B: begin
                n_a1    = rd_x;
                n_b1    = rd_y;
                n_state = S_INS_W;
            end
            S_INS_W: begin
                n_cnt   = r_cnt + CNT_W'(1);
                n_sel   = 5'(ins_k);
                n_ok    = 1'b1;
                n_state = S_DONE;
            end
            S_DEL_W: begin
                n_cnt   = r_cnt - CNT_W'(1);
                n_sel   = (r_idx != '0) ? r_idx - 5'd1 : 5'd0;
                n_ok    = 1'b1;
                n_state = S_DONE;
            end
            S_WR_W: begin
                if (CNT_W'(r_idx) == r_cnt) begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
                n_ok    = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid = 1'b1;
                    n_ores   = (r_ok && (r_op == OP_EVAL || r_op == OP_INV)) ? r_res : '0;
                    n_osel   = r_sel;
                    n_ostat  = !r_ok;
                    n_ocnt   = 5'(r_cnt);
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_valid          = r_ovalid;
    assign o_result_value   = r_ores;
    assign o_selected_index = r_osel;
    assign o_status         = r_ostat;
    assign o_points_held    = r_ocnt;

endmodule

FILE: rtl/plct_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plct_chk
// Port-level checks of the curve table unit, bound to the top level.
// ----------------------------------------------------------------------------
module plct_chk
    import plct_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic                     o_stall,
    input  logic                     o_valid,
    input  logic                     i_stall,
    input  logic signed [DATA_W-1:0] o_result_value,
    input  logic                     o_status,
    input  logic [4:0]               o_points_held
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_value))
        else $error("result item changed while stalled");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_result_value == '0)
        else $error("rejected item carries a value");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_points_held <= 5'(MAX_POINTS))
        else $error("point count above table size");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("unit free straight after taking an item");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("unit not idle after reset");

endmodule

bind piecewise_linear_curve_table_unit plct_chk u_plct_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_result_value (o_result_value),
    .o_status       (o_status),
    .o_points_held  (o_points_held)
);
